// ===== src/mwf_pkg.sv =====
// ----------------------------------------------------------------------------
// mwf_pkg - shared types and constants for the maze wall follower
// Word layouts, request codes, headings and grid sizing.
// ----------------------------------------------------------------------------
package mwf_pkg;

  // coordinate and grid sizing
  localparam int COORD_W   = 6;
  localparam int GRID_SIDE = 64;
  localparam int MEM_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int CFG_DATA_W = COORD_W;

  // default grid extent
  localparam int DEF_GRID_WIDTH  = 64;
  localparam int DEF_GRID_HEIGHT = 64;

  // request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_STEP    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_EXIT_X  = 2'd2;
  localparam logic [1:0] CFG_EXIT_Y  = 2'd3;

  // headings
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // last probe slot, which is the back move
  localparam logic [1:0] PROBE_BACK = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_wall;
  } mwf_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [1:0]         move_dir;
    logic               moved;
    logic               solved;
  } mwf_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE
  } mwf_state_t;

endpackage

// ===== src/mwf_ram.sv =====
// ----------------------------------------------------------------------------
// mwf_ram - generic single-port RAM
// One read or write port, read data registered.
// ----------------------------------------------------------------------------
module mwf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/maze_wall_follower.sv =====
// ----------------------------------------------------------------------------
// maze_wall_follower - left-hand rule grid maze walker
// Holds a wall map in RAM and moves a robot at most one cell per step word.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req with start; a word is taken at a clock edge
//   where start is high and busy is low. Load words write one wall bit,
//   restart words put the robot on the start cell facing north, step words
//   move it by the left-hand rule. Every request word gives exactly one
//   result word on result, marked by valid for one cycle.
//   Load, restart and an ignored step (maze already solved) report in the
//   cycle after they are taken, and busy stays low.
//   A step probes the left, straight and right neighbours in turn through
//   the single RAM port, one read per cycle, pipelined so that a probe is
//   checked while the next is read; then the move state applies the move. A step
//   keeps busy high while it scans and moves, and reports in the cycle busy falls.
//   start_x, start_y, exit_x, exit_y are written through cfg_we, cfg_index
//   and cfg_data while the block is idle.
//   Reset puts the robot at cell 0,0 arriving from the south, clears the
//   solved flag and the registers; the wall map is not cleared and must be
//   loaded before it is walked. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module maze_wall_follower #(
  parameter int GRID_WIDTH  = mwf_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = mwf_pkg::DEF_GRID_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mwf_pkg::mwf_req_t                 req,
  output logic                              valid,
  output mwf_pkg::mwf_res_t                 result,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [mwf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import mwf_pkg::*;

  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int LIM_W  = (GRID_WIDTH  < GRID_SIDE) ? GRID_WIDTH  : GRID_SIDE;
  localparam int LIM_H  = (GRID_HEIGHT < GRID_SIDE) ? GRID_HEIGHT : GRID_SIDE;
  localparam logic [COORD_W:0] LIM_W_C = (COORD_W+1)'(LIM_W);
  localparam logic [COORD_W:0] LIM_H_C = (COORD_W+1)'(LIM_H);

  mwf_state_t state, state_next;

  logic [COORD_W-1:0] robot_x, robot_y;
  logic [COORD_W-1:0] start_x, start_y, exit_x, exit_y;
  logic [1:0]         came_from;
  logic               done_flag;
  logic [1:0]         scan_k;
  logic               prev_valid;
  logic               prev_ok;
  logic [1:0]         sel_dir;

  logic [1:0]         nb_dir;
  logic [COORD_W:0]   nb_x, nb_y;
  logic               nb_ok;
  logic               scan_hit;
  logic               accept;
  logic               load_inside;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_rdata;

  assign accept      = start && !busy;
  assign load_inside = ({1'b0, req.cell_x} < LIM_W_C) && ({1'b0, req.cell_y} < LIM_H_C);

  // previous probe was inside the grid and read an open cell
  assign scan_hit = prev_valid && prev_ok && !ram_rdata;

  // shared neighbour unit: one heading in, cell and inside flag out
  always_comb begin
    nb_x = {1'b0, robot_x};
    nb_y = {1'b0, robot_y};
    unique case (nb_dir)
      DIR_NORTH: nb_y = nb_y - 1'b1;
      DIR_EAST:  nb_x = nb_x + 1'b1;
      DIR_SOUTH: nb_y = nb_y + 1'b1;
      DIR_WEST:  nb_x = nb_x - 1'b1;
    endcase
    nb_ok = (nb_x < LIM_W_C) && (nb_y < LIM_H_C);
  end

  // wall map
  mwf_ram #(
    .WIDTH (1),
    .DEPTH (MEM_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.cell_wall),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.req_type == REQ_STEP && !done_flag) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || scan_k == PROBE_BACK) state_next = ST_MOVE;
      end
      ST_MOVE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs: handshake, neighbour select, ram port
  always_comb begin
    busy   = 1'b1;
    nb_dir = 2'(came_from + 2'd1 + scan_k);
    ram_we = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        ram_we = accept && req.req_type == REQ_LOAD && load_inside;
      end
      ST_SCAN: ;
      ST_MOVE: nb_dir = sel_dir;
      default: ;
    endcase
    ram_addr = ram_we ? {req.cell_y, req.cell_x} : {nb_y[COORD_W-1:0], nb_x[COORD_W-1:0]};
  end

  // control and walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= 1'b0;
      robot_x    <= '0;
      robot_y    <= '0;
      came_from  <= DIR_SOUTH;
      done_flag  <= 1'b0;
      start_x    <= '0;
      start_y    <= '0;
      exit_x     <= '0;
      exit_y     <= '0;
      scan_k     <= '0;
      prev_valid <= 1'b0;
    end else begin
      state <= state_next;
      // result strobe: end of a step, or any word that reports at once
      valid <= (state == ST_MOVE)
               || (state == ST_IDLE && accept && !(req.req_type == REQ_STEP && !done_flag));
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_X: start_x <= cfg_data;
          CFG_START_Y: start_y <= cfg_data;
          CFG_EXIT_X:  exit_x  <= cfg_data;
          CFG_EXIT_Y:  exit_y  <= cfg_data;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          scan_k     <= '0;
          prev_valid <= 1'b0;
          if (accept) begin
            if (req.req_type == REQ_RESTART) begin
              robot_x   <= start_x;
              robot_y   <= start_y;
              came_from <= DIR_SOUTH;
              done_flag <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_hit && scan_k != PROBE_BACK) begin
            prev_valid <= 1'b1;
            scan_k     <= 2'(scan_k + 2'd1);
          end
        end
        ST_MOVE: begin
          if (nb_ok) begin
            robot_x   <= nb_x[COORD_W-1:0];
            robot_y   <= nb_y[COORD_W-1:0];
            came_from <= 2'(sel_dir + 2'd2);
            done_flag <= (nb_x[COORD_W-1:0] == exit_x) && (nb_y[COORD_W-1:0] == exit_y);
          end
        end
        default: ;
      endcase
    end
  end

  // probe flag, chosen heading and result word
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req.req_type == REQ_RESTART) begin
          result <= '{pos_x: start_x, pos_y: start_y, move_dir: DIR_NORTH,
                      moved: 1'b0, solved: 1'b0};
        end else begin
          result <= '{pos_x: robot_x, pos_y: robot_y, move_dir: DIR_NORTH,
                      moved: 1'b0, solved: done_flag};
        end
      end
      ST_SCAN: begin
        prev_ok <= nb_ok;
        sel_dir <= scan_hit ? 2'(came_from + scan_k) : came_from;
      end
      ST_MOVE: begin
        if (nb_ok) begin
          result <= '{pos_x: nb_x[COORD_W-1:0], pos_y: nb_y[COORD_W-1:0],
                      move_dir: sel_dir, moved: 1'b1,
                      solved: (nb_x[COORD_W-1:0] == exit_x)
                              && (nb_y[COORD_W-1:0] == exit_y)};
        end else begin
          result <= '{pos_x: robot_x, pos_y: robot_y, move_dir: DIR_NORTH,
                      moved: 1'b0, solved: done_flag};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/mwf_checker.sv =====
// ----------------------------------------------------------------------------
// mwf_checker - port-level checks for the maze wall follower
// Watches the request and result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module mwf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input mwf_pkg::mwf_req_t              req,
  input logic                           valid,
  input mwf_pkg::mwf_res_t              result
);

  import mwf_pkg::*;

  // a result word never overlaps a step in progress
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result word while busy");

  // every taken word either reports next cycle or starts a step
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (valid || busy))
    else $error("request word dropped");

  // finishing a step always reports
  a_step_reports: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> valid)
    else $error("step finished without result word");

  // restart reports an unmoved, unsolved robot
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_RESTART)
      |=> (valid && !result.moved && !result.solved))
    else $error("restart result wrong");

endmodule

bind maze_wall_follower mwf_checker u_mwf_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the maze wall follower
// A class keeps its own copy of the wall map and the walker, predicts the
// result word for every request word taken, and checks each result word as it
// comes. Directed words cover two grid corners, a blocked back move, solving
// and the ignored words; random walks then build mazes cell by cell around
// the walker, with random gaps on the request side.
// ----------------------------------------------------------------------------
module testbench;
  import mwf_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 650;
  localparam int SETTLE      = 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // walker prediction and result checking
  class maze_scoreboard;
    bit                 wall_map [GRID_SIDE][GRID_SIDE];
    bit                 written [GRID_SIDE][GRID_SIDE];
    logic [COORD_W-1:0] rob_x, rob_y;
    logic [COORD_W-1:0] start_x, start_y, exit_x, exit_y;
    logic [1:0]         arrived_from;
    bit                 solved_flag;
    mwf_res_t           expected_moves[$];
    int                 errors, steps, moves, solves, blocked;

    function new();
      rob_x = '0;
      rob_y = '0;
      start_x = '0;
      start_y = '0;
      exit_x = '0;
      exit_y = '0;
      arrived_from = DIR_SOUTH;
      solved_flag = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [COORD_W-1:0] val);
      case (idx)
        CFG_START_X: start_x = val;
        CFG_START_Y: start_y = val;
        CFG_EXIT_X:  exit_x = val;
        default:     exit_y = val;
      endcase
    endfunction

    function void neighbour(input logic [1:0] d, output int nx, output int ny);
      nx = int'(rob_x);
      ny = int'(rob_y);
      case (d)
        DIR_NORTH: ny = ny - 1;
        DIR_EAST:  nx = nx + 1;
        DIR_SOUTH: ny = ny + 1;
        default:   nx = nx - 1;
      endcase
    endfunction

    function bit on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < DEF_GRID_WIDTH && y < DEF_GRID_HEIGHT;
    endfunction

    function bit is_open(logic [1:0] d);
      int nx, ny;
      neighbour(d, nx, ny);
      if (!on_grid(nx, ny))
        return 1'b0;
      return wall_map[ny][nx] == 1'b0;
    endfunction

    // left, straight, right, else back the way it came
    function void walk_left_hand(inout mwf_res_t r);
      logic [1:0] head, pick;
      logic [1:0] order [3];
      bit         found;
      int         nx, ny;
      head = arrived_from + 2'd2;
      order[0] = head + 2'd3;
      order[1] = head;
      order[2] = head + 2'd1;
      pick = arrived_from;
      found = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (!found && is_open(order[i])) begin
          pick = order[i];
          found = 1'b1;
        end
      end
      neighbour(pick, nx, ny);
      steps++;
      if (on_grid(nx, ny)) begin
        rob_x = nx[COORD_W-1:0];
        rob_y = ny[COORD_W-1:0];
        arrived_from = pick + 2'd2;
        r.move_dir = pick;
        r.moved = 1'b1;
        moves++;
        if (rob_x == exit_x && rob_y == exit_y) begin
          solved_flag = 1'b1;
          solves++;
        end
      end else begin
        blocked++;
      end
    endfunction

    // predict the result word of an accepted request word
    function void note_word(mwf_req_t w);
      mwf_res_t r;
      r.move_dir = DIR_NORTH;
      r.moved = 1'b0;
      case (w.req_type)
        REQ_LOAD: begin
          wall_map[w.cell_y][w.cell_x] = w.cell_wall;
          written[w.cell_y][w.cell_x] = 1'b1;
        end
        REQ_RESTART: begin
          rob_x = start_x;
          rob_y = start_y;
          arrived_from = DIR_SOUTH;
          solved_flag = 1'b0;
        end
        REQ_STEP: begin
          if (!solved_flag)
            walk_left_hand(r);
        end
        default: ;
      endcase
      r.pos_x = rob_x;
      r.pos_y = rob_y;
      r.solved = solved_flag;
      expected_moves = {expected_moves, r};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20)
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // compare a result word with the oldest prediction
    task check_word(mwf_res_t r);
      mwf_res_t e;
      if (expected_moves.size() == 0) begin
        report($sformatf("result word with nothing pending (pos %0d,%0d)",
                         r.pos_x, r.pos_y));
      end else begin
        e = expected_moves.pop_front();
        if (r.pos_x !== e.pos_x)
          report($sformatf("pos_x got %0d expected %0d", r.pos_x, e.pos_x));
        if (r.pos_y !== e.pos_y)
          report($sformatf("pos_y got %0d expected %0d", r.pos_y, e.pos_y));
        if (r.move_dir !== e.move_dir)
          report($sformatf("move_dir got %0d expected %0d", r.move_dir, e.move_dir));
        if (r.moved !== e.moved)
          report($sformatf("moved got %0d expected %0d", r.moved, e.moved));
        if (r.solved !== e.solved)
          report($sformatf("solved got %0d expected %0d", r.solved, e.solved));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  mwf_req_t              req = '0;
  logic                  valid;
  mwf_res_t              result;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  maze_scoreboard sb;
  int             items_done;
  int             quiet_cycles;
  int             wall_pct = 35;
  bit             no_gaps;

  always #4 clk = ~clk;

  maze_wall_follower dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .valid     (valid),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result monitor
  always @(posedge clk) begin
    if (!rst && valid)
      sb.check_word(result);
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("FAIL maze_wall_follower");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 10)
      return 0;
    if (r < 17)
      return $urandom_range(1, 3);
    if (r < 19)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom_range(0, GRID_SIDE - 1));
    endcase
  endfunction

  function logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0)
      v = 0;
    if (v > GRID_SIDE - 1)
      v = GRID_SIDE - 1;
    return v[COORD_W-1:0];
  endfunction

  // offer one request word and hold it until taken
  task send_word(mwf_req_t w);
    int gap;
    bit was_solved;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= w;
    do @(posedge clk); while (busy);
    was_solved = sb.solved_flag;
    sb.note_word(w);
    if (!(w.req_type == REQ_STEP && was_solved))
      items_done++;
  endtask

  task send_load(int x, int y, bit wall);
    mwf_req_t w;
    w.req_type = REQ_LOAD;
    w.cell_x = x[COORD_W-1:0];
    w.cell_y = y[COORD_W-1:0];
    w.cell_wall = wall;
    send_word(w);
  endtask

  // non-load word with don't-care cell fields
  task send_cmd(logic [1:0] code);
    mwf_req_t w;
    w.req_type = code;
    w.cell_x = COORD_W'($urandom_range(0, GRID_SIDE - 1));
    w.cell_y = COORD_W'($urandom_range(0, GRID_SIDE - 1));
    w.cell_wall = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // let every pending result word arrive and the block settle
  task wait_idle();
    start <= 1'b0;
    while (sb.expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all four registers on consecutive cycles
  task write_course(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                    logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
    logic [COORD_W-1:0] vals [4];
    vals[CFG_START_X] = sx;
    vals[CFG_START_Y] = sy;
    vals[CFG_EXIT_X]  = ex;
    vals[CFG_EXIT_Y]  = ey;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(i[1:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // load any unwritten cell next to the walker so no step reads undefined map
  task fill_around();
    int nx, ny;
    for (int d = 0; d < 4; d++) begin
      sb.neighbour(d[1:0], nx, ny);
      if (sb.on_grid(nx, ny) && !sb.written[ny][nx])
        send_load(nx, ny, $urandom_range(0, 99) < wall_pct);
    end
  endtask

  task directed_words();
    // bottom right corner: back move off the grid, then solve, then ignored words
    write_course('1, '1, '1, 6'd62);
    send_load(62, 63, 1'b1);
    send_load(63, 62, 1'b1);
    send_cmd(REQ_RESTART);
    send_cmd(REQ_STEP);
    send_load(63, 62, 1'b0);
    send_cmd(REQ_STEP);
    send_cmd(REQ_STEP);
    send_cmd(REQ_UNUSED);
    send_cmd(REQ_RESTART);
    wait_idle();
    // top left corner with start on the exit: back move south, then back home
    write_course('0, '0, '0, '0);
    send_load(1, 0, 1'b1);
    send_load(0, 1, 1'b0);
    send_cmd(REQ_RESTART);
    send_cmd(REQ_STEP);
    send_load(1, 1, 1'b1);
    send_load(0, 2, 1'b1);
    send_load(0, 0, 1'b0);
    send_cmd(REQ_STEP);
  endtask

  // one random walk: new course, restart, steps with some noise mixed in
  task walk_maze();
    logic [COORD_W-1:0] sx, sy, ex, ey;
    int                 r, nx, ny;
    wait_idle();
    sx = pick_coord();
    sy = pick_coord();
    r = $urandom_range(0, 9);
    if (r < 5) begin
      ex = nudge(sx);
      ey = nudge(sy);
    end else if (r < 6) begin
      ex = sx;
      ey = sy;
    end else begin
      ex = pick_coord();
      ey = pick_coord();
    end
    write_course(sx, sy, ex, ey);
    wall_pct = $urandom_range(20, 50);
    no_gaps = $urandom_range(0, 5) == 0;
    send_cmd(REQ_RESTART);
    repeat ($urandom_range(8, 40)) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_load($urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1),
                  1'($urandom_range(0, 1)));
      end else if (r < 10) begin
        sb.neighbour(2'($urandom_range(0, 3)), nx, ny);
        if (sb.on_grid(nx, ny))
          send_load(nx, ny, 1'($urandom_range(0, 1)));
      end else if (r < 12) begin
        send_cmd(REQ_UNUSED);
      end else if (r < 14) begin
        send_cmd(REQ_RESTART);
      end
      fill_around();
      send_cmd(REQ_STEP);
      if (sb.solved_flag) begin
        if ($urandom_range(0, 3) == 0)
          send_cmd(REQ_STEP);
        break;
      end
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_words();
    while (items_done < ITEM_TARGET)
      walk_maze();
    wait_idle();
    $display("%0d request words: %0d steps, %0d moves, %0d solves, %0d blocked back moves",
             items_done, sb.steps, sb.moves, sb.solves, sb.blocked);
    $display("%0d result mismatches", sb.errors);
    if (sb.errors == 0)
      $display("PASS maze_wall_follower");
    else
      $display("FAIL maze_wall_follower");
    $finish;
  end

endmodule
